@@ rtl/scalar_kalman_filter_core_defines.svh @@
// ----------------------------------------------------------------------------
// Scalar Kalman filter assertion macros
// Shared property shorthands for the checker of the filter core.
// ----------------------------------------------------------------------------
`ifndef SCALAR_KALMAN_FILTER_CORE_DEFINES_SVH
`define SCALAR_KALMAN_FILTER_CORE_DEFINES_SVH

// Same-cycle implication, off while reset is held
`define SKF_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("skf checker: same-cycle property failed");

// Next-cycle implication, off while reset is held
`define SKF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("skf checker: next-cycle property failed");

`endif

@@ rtl/skf_pkg.sv @@
// ----------------------------------------------------------------------------
// Scalar Kalman filter package
// Formats, reset values, register indexes, state and command types.
// ----------------------------------------------------------------------------
package skf_pkg;

  // Sample and variance formats
  localparam int DATA_W        = 32;
  localparam int VAR_FRAC_BITS = 24;
  localparam int GAIN_W        = VAR_FRAC_BITS + 1;
  localparam int DEN_W         = DATA_W + 1;
  localparam int PROD_W        = DEN_W + GAIN_W;
  localparam int OUT_TDATA_W   = ((DATA_W + GAIN_W + 7) / 8) * 8;
  localparam int PAD_W         = OUT_TDATA_W - DATA_W - GAIN_W;

  localparam logic [GAIN_W-1:0] VAR_ONE  = GAIN_W'(1) << VAR_FRAC_BITS;
  localparam logic [PROD_W:0]   VAR_HALF = (PROD_W+1)'(1) << (VAR_FRAC_BITS - 1);

  // Divider sequencing: one quotient bit per cycle
  localparam int DIV_STEPS = GAIN_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  // Register reset values: Q = 0.0005, R = 0.1 in variance format
  localparam logic [DATA_W-1:0] Q_RESET = 32'd8389;
  localparam logic [DATA_W-1:0] R_RESET = 32'd1677722;

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_PROCESS_NOISE     = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_MEASUREMENT_NOISE = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PRED,
    ST_DIV,
    ST_MUL_EST,
    ST_MUL_VAR,
    ST_FINISH
  } skf_state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;
    logic pred;
    logic div_step;
    logic div_first;
    logic mul_est;
    logic mul_var;
    logic finish;
  } skf_cmd_t;

endpackage

@@ rtl/skf_datapath.sv @@
// ----------------------------------------------------------------------------
// Scalar Kalman filter datapath
// Holds the state, noise registers, restoring gain divider, shared
// multiplier and the result register.
// ----------------------------------------------------------------------------
module skf_datapath (
  input  logic                             clk,
  input  logic                             rst_n,
  input  skf_pkg::skf_cmd_t                cmd,
  input  logic                             cfg_we,
  input  logic [skf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [skf_pkg::DATA_W-1:0]       cfg_data,
  input  logic signed [skf_pkg::DATA_W-1:0] measurement,
  input  logic                             restart,
  output logic signed [skf_pkg::DATA_W-1:0] res_estimate,
  output logic [skf_pkg::GAIN_W-1:0]       res_gain
);

  localparam int DW = skf_pkg::DATA_W;
  localparam int GW = skf_pkg::GAIN_W;
  localparam int NW = skf_pkg::DEN_W;
  localparam int PW = skf_pkg::PROD_W;
  localparam int XW = PW + 1 - skf_pkg::VAR_FRAC_BITS;

  logic [DW-1:0]        q_noise_r;
  logic [DW-1:0]        r_noise_r;
  logic signed [DW-1:0] est_r;
  logic [DW-1:0]        var_r;
  logic signed [DW-1:0] z_r;
  logic [DW-1:0]        pm_r;
  logic [NW-1:0]        den_r;
  logic                 den_zero_r;
  logic [NW-1:0]        rem_r;
  logic [GW-1:0]        quo_r;
  logic                 d_neg_r;
  logic [NW-1:0]        mag_r;
  logic [PW-1:0]        prod_r;
  logic signed [DW-1:0] res_est_r;
  logic [GW-1:0]        res_gain_r;

  logic [NW-1:0]        pm_sum;
  logic [DW-1:0]        pm_sat;
  logic [NW-1:0]        den_nxt;
  logic signed [NW-1:0] diff;
  logic [NW:0]          shifted;
  logic                 ge;
  logic [NW:0]          rem_sub;
  logic [NW-1:0]        mul_a;
  logic [GW-1:0]        mul_b;
  logic [GW-1:0]        one_minus_k;
  logic [PW-1:0]        prod;
  logic [PW:0]          round_sum;
  logic [XW-1:0]        rounded;
  logic signed [XW:0]   est_ext;
  logic signed [XW:0]   xn;
  logic signed [DW-1:0] est_sat;
  logic [DW-1:0]        var_sat;

  // Predicted variance, denominator and innovation
  always_comb begin
    pm_sum  = {1'b0, var_r} + {1'b0, q_noise_r};
    pm_sat  = pm_sum[DW] ? '1 : pm_sum[DW-1:0];
    den_nxt = {1'b0, pm_sat} + {1'b0, r_noise_r};
    diff    = {z_r[DW-1], z_r} - {est_r[DW-1], est_r};
  end

  // Restoring divider step: first step compares without a shift
  always_comb begin
    shifted = cmd.div_first ? {1'b0, rem_r} : {rem_r, 1'b0};
    ge      = shifted >= {1'b0, den_r};
    rem_sub = shifted - {1'b0, den_r};
  end

  // Shared multiplier: innovation times gain, then (1 - gain) times variance
  always_comb begin
    one_minus_k = skf_pkg::VAR_ONE - quo_r;
    mul_a       = cmd.mul_var ? {1'b0, pm_r} : mag_r;
    mul_b       = cmd.mul_var ? one_minus_k : quo_r;
    prod        = mul_a * mul_b;
  end

  // Round the registered product and saturate both updates
  always_comb begin
    round_sum = {1'b0, prod_r} + skf_pkg::VAR_HALF;
    rounded   = round_sum[PW:skf_pkg::VAR_FRAC_BITS];
    est_ext   = (XW+1)'(est_r);
    xn        = d_neg_r ? (est_ext - $signed({1'b0, rounded}))
                        : (est_ext + $signed({1'b0, rounded}));
    if (xn > $signed({{(XW+1-DW){1'b0}}, 1'b0, {(DW-1){1'b1}}})) begin
      est_sat = {1'b0, {(DW-1){1'b1}}};
    end else if (xn < $signed({{(XW+1-DW){1'b1}}, 1'b1, {(DW-1){1'b0}}})) begin
      est_sat = {1'b1, {(DW-1){1'b0}}};
    end else begin
      est_sat = xn[DW-1:0];
    end
    var_sat = (|rounded[XW-1:DW]) ? '1 : rounded[DW-1:0];
  end

  // Noise registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_noise_r <= skf_pkg::Q_RESET;
      r_noise_r <= skf_pkg::R_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        skf_pkg::CFG_IDX_PROCESS_NOISE:     q_noise_r <= cfg_data;
        skf_pkg::CFG_IDX_MEASUREMENT_NOISE: r_noise_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Filter state: clear on restart, update estimate then variance
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      est_r <= '0;
      var_r <= '0;
    end else begin
      if (cmd.load && restart) begin
        est_r <= '0;
        var_r <= '0;
      end
      if (cmd.mul_var) begin
        est_r <= est_sat;
      end
      if (cmd.finish) begin
        var_r <= var_sat;
      end
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      z_r <= measurement;
    end
    if (cmd.pred) begin
      pm_r       <= pm_sat;
      den_r      <= den_nxt;
      den_zero_r <= (den_nxt == '0);
      rem_r      <= {1'b0, pm_sat};
      quo_r      <= '0;
      d_neg_r    <= diff[NW-1];
      mag_r      <= diff[NW-1] ? NW'(-diff) : NW'(diff);
    end
    if (cmd.div_step) begin
      rem_r <= ge ? rem_sub[NW-1:0] : shifted[NW-1:0];
      quo_r <= {quo_r[GW-2:0], ge & ~den_zero_r};
    end
    if (cmd.mul_est || cmd.mul_var) begin
      prod_r <= prod;
    end
    if (cmd.finish) begin
      res_est_r  <= est_r;
      res_gain_r <= quo_r;
    end
  end

  assign res_estimate = res_est_r;
  assign res_gain     = res_gain_r;

endmodule

@@ rtl/skf_ctrl.sv @@
// ----------------------------------------------------------------------------
// Scalar Kalman filter controller
// Sequences predict, divide, multiply and finish for one sample at a time
// and owns the result valid flag.
// ----------------------------------------------------------------------------
module skf_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output skf_pkg::skf_cmd_t cmd
);

  skf_pkg::skf_state_t            state_r, state_nxt;
  logic [skf_pkg::CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                           out_valid_r, out_valid_nxt;

  // State, counter and valid registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= skf_pkg::ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    cmd           = '0;
    in_ready      = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      skf_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = skf_pkg::ST_PRED;
        end
      end
      skf_pkg::ST_PRED: begin
        cmd.pred  = 1'b1;
        cnt_nxt   = '0;
        state_nxt = skf_pkg::ST_DIV;
      end
      skf_pkg::ST_DIV: begin
        cmd.div_step  = 1'b1;
        cmd.div_first = (cnt_r == '0);
        if (cnt_r == skf_pkg::CNT_W'(skf_pkg::DIV_STEPS - 1)) begin
          state_nxt = skf_pkg::ST_MUL_EST;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      skf_pkg::ST_MUL_EST: begin
        cmd.mul_est = 1'b1;
        state_nxt   = skf_pkg::ST_MUL_VAR;
      end
      skf_pkg::ST_MUL_VAR: begin
        cmd.mul_var = 1'b1;
        state_nxt   = skf_pkg::ST_FINISH;
      end
      skf_pkg::ST_FINISH: begin
        // Hold until the result register is free
        if (!out_valid_r || out_ready) begin
          cmd.finish    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = skf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = skf_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

@@ rtl/scalar_kalman_filter_core.sv @@
// ----------------------------------------------------------------------------
// Scalar Kalman filter core: one-dimensional smoother for angle samples
// One sample at a time: a new input word is accepted only after the previous
// result is written to the result register; the gain divider runs in 25 steps.
// Reset: synchronous; estimate and variance clear, Q and R load defaults.
// ----------------------------------------------------------------------------
module scalar_kalman_filter_core (
  input  logic                                clk,
  input  logic                                rst_n,
  // Input stream
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [skf_pkg::DATA_W-1:0]          in_tdata,   // [31:0] measurement
  input  logic [0:0]                          in_tuser,   // [0] restart
  // Result stream
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [skf_pkg::OUT_TDATA_W-1:0]     out_tdata,  // [31:0] estimate, [56:32] gain,
                                                          // [63:57] zero
  // Configuration write channel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [skf_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [skf_pkg::DATA_W-1:0]          cfg_data
);

  skf_pkg::skf_cmd_t                  cmd;
  logic signed [skf_pkg::DATA_W-1:0]  res_estimate;
  logic [skf_pkg::GAIN_W-1:0]         res_gain;

  // Accept configuration words every cycle
  assign cfg_ready = 1'b1;

  skf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .cmd       (cmd)
  );

  skf_datapath u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .cfg_we       (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .measurement  (in_tdata),
    .restart      (in_tuser[0]),
    .res_estimate (res_estimate),
    .res_gain     (res_gain)
  );

  // Pack the result word
  assign out_tdata = {{skf_pkg::PAD_W{1'b0}}, res_gain, res_estimate};

endmodule

@@ rtl/skf_checker.sv @@
// ----------------------------------------------------------------------------
// Scalar Kalman filter port checker
// Watches the core's ports over time; attached to the core by bind.
// ----------------------------------------------------------------------------
`include "scalar_kalman_filter_core_defines.svh"

module skf_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [skf_pkg::OUT_TDATA_W-1:0] out_tdata
);

  // A stalled result word holds
  `SKF_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))

  // One sample at a time: busy right after an accept
  `SKF_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_tvalid && in_tready, !in_tready)

  // Gain never exceeds one
  `SKF_ASSERT_SAME(a_gain_range, clk, rst_n, out_tvalid, out_tdata[skf_pkg::DATA_W +: skf_pkg::GAIN_W] <= skf_pkg::VAR_ONE)

  // Pad bits of the result word stay zero
  `SKF_ASSERT_SAME(a_pad_zero, clk, rst_n, out_tvalid, out_tdata[skf_pkg::OUT_TDATA_W-1 -: skf_pkg::PAD_W] == '0)

endmodule

bind scalar_kalman_filter_core skf_checker u_skf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

@@ sim/scalar_kalman_filter_core_tb.sv @@
// ----------------------------------------------------------------------------
// Scalar Kalman filter core testbench
// Streams angle words through the filter core and predicts every estimate
// and gain from its own copy of the filter state and noise settings. Covers
// the default noise settings, zero and saturated noise values, restarts, and
// random noise phases with idle gaps and back-pressure on both streams.
// ----------------------------------------------------------------------------
module scalar_kalman_filter_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          CLK_HALF    = 10;
  localparam int          CYCLE_LIMIT = 500000;
  localparam int          DRAIN_WAIT  = 40;
  localparam int          PHASES      = 7;
  localparam int          PHASE_WORDS = 75;
  localparam bit [63:0]   UNITY_GAIN  = 64'd1 << skf_pkg::VAR_FRAC_BITS;
  localparam bit [63:0]   ALL_ONES_32 = 64'hFFFF_FFFF;
  localparam logic [31:0] MEAS_MAX    = 32'h7FFF_FFFF;
  localparam logic [31:0] MEAS_MIN    = 32'h8000_0000;

  // One filtered result word
  typedef struct packed {
    logic signed [skf_pkg::DATA_W-1:0] estimate;
    logic [skf_pkg::GAIN_W-1:0]        gain;
  } filter_result_t;

  logic                            clk;
  logic                            rst_n;
  logic                            in_tvalid;
  logic                            in_tready;
  logic [skf_pkg::DATA_W-1:0]      in_tdata;   // [31:0] measurement
  logic [0:0]                      in_tuser;   // [0] restart
  logic                            out_tvalid;
  logic                            out_tready;
  logic [skf_pkg::OUT_TDATA_W-1:0] out_tdata;  // [31:0] estimate, [56:32] gain, [63:57] zero
  logic                            cfg_valid;
  logic                            cfg_ready;
  logic [skf_pkg::CFG_IDX_W-1:0]   cfg_index;
  logic [skf_pkg::DATA_W-1:0]      cfg_data;

  // Filter state and noise settings as the block should hold them
  logic signed [skf_pkg::DATA_W-1:0] est_track;
  logic [skf_pkg::DATA_W-1:0]        var_track;
  logic [skf_pkg::DATA_W-1:0]        q_noise;
  logic [skf_pkg::DATA_W-1:0]        r_noise;

  filter_result_t expected_results[$];

  int  fail_count;
  int  cycle_count;
  int  words_sent;
  int  words_checked;
  int  restarts_sent;
  int  noise_settings;
  int  stall_left;
  bit  tx_free;
  bit  rx_free;
  int  angle;

  scalar_kalman_filter_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #CLK_HALF clk = ~clk;

  // Idle length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Advance the filter by one measurement and return the expected word
  function automatic filter_result_t track_measurement(
    logic signed [skf_pkg::DATA_W-1:0] z,
    logic                              restart
  );
    bit [63:0]      pm, den, k, mag, corr, pn;
    longint         diff, xn;
    filter_result_t res;
    if (restart) begin
      est_track = '0;
      var_track = '0;
    end
    // Predicted variance, saturated to 32 bits
    pm = {32'b0, var_track} + {32'b0, q_noise};
    if (pm > ALL_ONES_32) pm = ALL_ONES_32;
    // Gain, zero when the denominator vanishes
    den = pm + {32'b0, r_noise};
    k = (den == 0) ? 64'd0 : (pm << skf_pkg::VAR_FRAC_BITS) / den;
    if (k > UNITY_GAIN) k = UNITY_GAIN;
    // Correction rounds to nearest, ties away from zero
    diff = longint'(z) - longint'(est_track);
    mag  = (diff < 0) ? -diff : diff;
    corr = (mag * k + (UNITY_GAIN >> 1)) >> skf_pkg::VAR_FRAC_BITS;
    xn   = (diff < 0) ? longint'(est_track) - longint'(corr)
                      : longint'(est_track) + longint'(corr);
    if (xn > 64'sd2147483647)       est_track = MEAS_MAX;
    else if (xn < -64'sd2147483648) est_track = MEAS_MIN;
    else                            est_track = xn[31:0];
    // Variance update rounds to nearest, ties up
    pn = ((UNITY_GAIN - k) * pm + (UNITY_GAIN >> 1)) >> skf_pkg::VAR_FRAC_BITS;
    if (pn > ALL_ONES_32) pn = ALL_ONES_32;
    var_track = pn[31:0];
    res.estimate = est_track;
    res.gain     = k[skf_pkg::GAIN_W-1:0];
    return res;
  endfunction

  // Send one measurement word; hold valid high when no gap follows
  task automatic send_measurement(logic [skf_pkg::DATA_W-1:0] meas, logic restart);
    int gap;
    in_tvalid <= 1'b1;
    in_tdata  <= meas;
    in_tuser  <= restart;
    do @(posedge clk); while (!in_tready);
    expected_results.push_back(track_measurement(meas, restart));
    words_sent++;
    if (restart) restarts_sent++;
    gap = tx_free ? 0 : pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drop valid and wait until every expected word has come back
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  // Write both noise registers back to back; call only when idle
  task automatic set_noise(logic [skf_pkg::DATA_W-1:0] q, logic [skf_pkg::DATA_W-1:0] r);
    cfg_valid <= 1'b1;
    cfg_index <= skf_pkg::CFG_IDX_PROCESS_NOISE;
    cfg_data  <= q;
    do @(posedge clk); while (!cfg_ready);
    q_noise = q;
    cfg_index <= skf_pkg::CFG_IDX_MEASUREMENT_NOISE;
    cfg_data  <= r;
    do @(posedge clk); while (!cfg_ready);
    r_noise = r;
    cfg_valid <= 1'b0;
    noise_settings++;
  endtask

  // Noise value: extremes, full range or a typical small variance
  function automatic logic [skf_pkg::DATA_W-1:0] pick_noise();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    if (r <= 3) return $urandom;
    return $urandom_range(1, 1 << 25);
  endfunction

  // Measurement: mostly a slowly moving angle, some jumps and extremes
  function automatic logic [skf_pkg::DATA_W-1:0] pick_measurement();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return MEAS_MAX;
    if (r == 1) return MEAS_MIN;
    if (r <= 5) return $urandom;
    angle = angle + $signed($urandom_range(0, 1 << 19)) - (1 << 18);
    return angle;
  endfunction

  // Default noise settings, full-scale innovations and restarts
  task automatic test_reset_defaults();
    send_measurement(32'd0, 1'b1);
    send_measurement(MEAS_MAX, 1'b0);
    send_measurement(MEAS_MIN, 1'b0);
    send_measurement(MEAS_MAX, 1'b0);
    send_measurement(32'd1, 1'b0);
    send_measurement(32'hFFFF_FFFF, 1'b0);
    send_measurement(MEAS_MIN, 1'b1);
    send_measurement(32'h0003_0000, 1'b0);
  endtask

  // Zero denominator holds the estimate; zero predicted variance gives no gain
  task automatic test_zero_noise();
    drain_results();
    set_noise('0, '0);
    send_measurement(MEAS_MAX, 1'b1);
    send_measurement(MEAS_MIN, 1'b0);
    drain_results();
    set_noise('0, '1);
    send_measurement(32'd1000, 1'b1);
  endtask

  // Unity gain with saturated variance, half gain, then gains of one third and below
  task automatic test_gain_extremes();
    drain_results();
    set_noise('1, '0);
    send_measurement(MEAS_MAX, 1'b1);
    send_measurement(MEAS_MIN, 1'b0);
    send_measurement(MEAS_MAX, 1'b0);
    drain_results();
    set_noise('1, '1);
    send_measurement(MEAS_MIN, 1'b0);
    send_measurement(MEAS_MAX, 1'b0);
    send_measurement(32'd0, 1'b0);
    drain_results();
    set_noise(32'd1, '1);
    send_measurement(MEAS_MAX, 1'b0);
    send_measurement(MEAS_MIN, 1'b0);
  endtask

  // Random noise phases; some phases run one or both streams without idling
  task automatic test_random_phases();
    for (int p = 0; p < PHASES; p++) begin
      drain_results();
      set_noise(pick_noise(), pick_noise());
      tx_free = ($urandom_range(0, 3) == 0);
      rx_free = ($urandom_range(0, 3) == 0);
      angle   = $urandom;
      for (int i = 0; i < PHASE_WORDS; i++) begin
        send_measurement(pick_measurement(), ($urandom_range(0, 19) == 0));
      end
    end
    tx_free = 1'b0;
    rx_free = 1'b0;
  endtask

  // Random back-pressure on the result stream
  always @(posedge clk) begin
    if (rx_free) begin
      out_tready <= 1'b1;
    end else if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left--;
    end else begin
      out_tready <= 1'b1;
      stall_left = pick_gap();
    end
  end

  // Compare each accepted result word with the oldest expectation
  always @(posedge clk) begin
    filter_result_t exp_res;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_results.size() == 0) begin
        $error("result word with nothing expected: %h", out_tdata);
        fail_count++;
      end else begin
        exp_res = expected_results.pop_front();
        words_checked++;
        if (out_tdata[skf_pkg::DATA_W-1:0] !== exp_res.estimate) begin
          $error("estimate: expected %h, got %h", exp_res.estimate,
                 out_tdata[skf_pkg::DATA_W-1:0]);
          fail_count++;
        end
        if (out_tdata[skf_pkg::DATA_W +: skf_pkg::GAIN_W] !== exp_res.gain) begin
          $error("gain: expected %h, got %h", exp_res.gain,
                 out_tdata[skf_pkg::DATA_W +: skf_pkg::GAIN_W]);
          fail_count++;
        end
      end
    end
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("** scalar_kalman_filter_core: FAILED **");
      $finish;
    end
  end

  initial begin
    clk        = 1'b0;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = '0;
    out_tready = 1'b0;
    cfg_valid  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    stall_left = 0;
    tx_free    = 1'b0;
    rx_free    = 1'b0;
    angle      = 0;
    est_track  = '0;
    var_track  = '0;
    q_noise    = skf_pkg::Q_RESET;
    r_noise    = skf_pkg::R_RESET;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_zero_noise();
    test_gain_extremes();
    test_random_phases();

    // Wait out the last words
    drain_results();
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Sent %0d measurement words (%0d restarts) over %0d noise settings,",
             words_sent, restarts_sent, noise_settings);
    $display("checked %0d result words with idle gaps and back-pressure.", words_checked);
    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("** scalar_kalman_filter_core: PASSED **");
    end else begin
      $display("** scalar_kalman_filter_core: FAILED **");
    end
    $finish;
  end

endmodule

@@ scalar_kalman_filter_core.f @@
+incdir+rtl
rtl/skf_pkg.sv
rtl/skf_datapath.sv
rtl/skf_ctrl.sv
rtl/scalar_kalman_filter_core.sv
rtl/skf_checker.sv
sim/scalar_kalman_filter_core_tb.sv
